// ===== rtl/fqr_pkg.sv =====
// Package: sizes, action codes and cell control types for the tag queue.
`timescale 1ns / 1ps

package fqr_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_BITS  = 32;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int ACTION_W    = 2;
   localparam int ITEM_W      = 32;
   localparam int OUT_VALUE_W = 32;
   localparam int COUNT_OUT_W = 5;

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [CNT_W-1:0]      count_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ENQ = 2'd0,
      ACT_DEQ = 2'd1,
      ACT_DEL = 2'd2
   } action_type;

   // Broadcast to every cell in the cycle a command is taken.
   typedef struct packed {
      logic enq;   // append at the tail cell
      logic deq;   // every cell takes its right neighbor
      logic del;   // cells at or after the first match take their right neighbor
   } cell_ctrl_type;

   // Passed from cell i to cell i+1.
   typedef struct packed {
      logic occ;   // this cell holds an entry
      logic hit;   // a match was found here or to the left
   } cell_link_type;

endpackage

// ===== rtl/fqr_cell.sv =====
// One queue slot: holds an entry, compares it, and shifts left on removal.
`timescale 1ns / 1ps

module fqr_cell
   import fqr_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  value_type     op_value,
   input  logic          occupied,
   input  cell_link_type link_in,
   output cell_link_type link_out,
   input  value_type     right_entry,
   output value_type     entry
);

   value_type entry_ff;
   value_type entry_in;
   logic      match_here;
   logic      tail_here;
   logic      shift;

   always_comb begin
      match_here = occupied && (entry_ff == op_value);
      tail_here  = link_in.occ && !occupied;
      shift      = ctrl.deq || (ctrl.del && (link_in.hit || match_here));

      entry_in = entry_ff;
      if (shift) begin
         entry_in = right_entry;
      end else if (ctrl.enq && tail_here) begin
         entry_in = op_value;
      end

      link_out.occ = occupied;
      link_out.hit = link_in.hit || match_here;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/fifo_queue_with_remove_by_value_unit.sv =====
// Top level: tag queue with enqueue, dequeue and delete-by-value over a row of cells.
`timescale 1ns / 1ps

// Channel   Ports                                        Transfer
// --------  -------------------------------------------  ---------------------------
// command   start, busy, req_action, req_item_value     start high while busy low
// result    rsp_valid, rsp_status, rsp_out_value,       rsp_valid high, one cycle
//           rsp_entry_count
//
// One command per clock. A command taken at an edge updates the cells and count
// at that edge; its result shows on the rsp_ ports for the following cycle.
// The whole match search is one compare in each cell plus a hit chain through
// the DEPTH cells, so that chain sets the clock period, not the rate.
// busy stays low: the next command may follow in the next cycle.
// Reset (synchronous) empties the queue; cell contents are not cleared, since
// only cells below the count are ever read. The receiver cannot stall.

module fifo_queue_with_remove_by_value_unit
   import fqr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [ITEM_W-1:0]      req_item_value,
   output logic                   rsp_valid,
   output logic                   rsp_status,
   output logic [OUT_VALUE_W-1:0] rsp_out_value,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count
);

   count_type                 count_ff;
   count_type                 count_in;
   logic                      valid_ff;
   logic                      valid_in;
   logic                      status_ff;
   logic                      status_in;
   logic [OUT_VALUE_W-1:0]    out_value_ff;
   logic [OUT_VALUE_W-1:0]    out_value_in;

   logic                      accept;
   value_type                 op_value;
   logic                      value_nz;
   logic                      enq_ok;
   logic                      deq_ok;
   logic                      del_req;
   logic                      del_ok;
   cell_ctrl_type             ctrl;

   value_type                 entries [DEPTH];
   value_type                 rights  [DEPTH];
   logic [DEPTH-1:0]          occupied;
   cell_link_type             links   [DEPTH+1];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign op_value = VALUE_BITS'(req_item_value);
   assign value_nz = (op_value != '0);

   // Command decode; unused action code falls to the error arm.
   always_comb begin
      enq_ok  = 1'b0;
      deq_ok  = 1'b0;
      del_req = 1'b0;
      unique case (action_type'(req_action))
         ACT_ENQ: begin
            enq_ok = accept && value_nz && (count_ff != CNT_W'(DEPTH));
         end
         ACT_DEQ: begin
            deq_ok = accept && (count_ff != '0);
         end
         ACT_DEL: begin
            del_req = accept && value_nz;
         end
         default: begin
         end
      endcase
   end

   assign ctrl.enq = enq_ok;
   assign ctrl.deq = deq_ok;
   assign ctrl.del = del_req;

   // Left edge of the chain: a virtual always-occupied cell with no hit.
   assign links[0].occ = 1'b1;
   assign links[0].hit = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign occupied[i] = (count_ff > CNT_W'(i));
      if (i == DEPTH - 1) begin : g_last
         assign rights[i] = '0;
      end else begin : g_mid
         assign rights[i] = entries[i+1];
      end

      fqr_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .op_value    (op_value),
         .occupied    (occupied[i]),
         .link_in     (links[i]),
         .link_out    (links[i+1]),
         .right_entry (rights[i]),
         .entry       (entries[i])
      );
   end

   // Delete succeeds when the hit chain found an occupied match.
   assign del_ok = del_req && links[DEPTH].hit;

   always_comb begin
      count_in = count_ff;
      if (enq_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (deq_ok || del_ok) begin
         count_in = count_ff - CNT_W'(1);
      end

      valid_in     = accept;
      status_in    = !(enq_ok || deq_ok || del_ok);
      out_value_in = deq_ok ? OUT_VALUE_W'(entries[0]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      out_value_ff <= out_value_in;
   end

   // Count register holds the value after the last transfer, matching the result.
   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_value   = out_value_ff;
   assign rsp_entry_count = COUNT_OUT_W'(count_ff);

endmodule

// ===== sim/tag_queue_checker.sv =====
// Checker: tracks the tag queue contents and compares every result with the expected one.
`timescale 1ns / 1ps

module tag_queue_checker
   import fqr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [ITEM_W-1:0]      req_item_value,
   input  logic                   rsp_valid,
   input  logic                   rsp_status,
   input  logic [OUT_VALUE_W-1:0] rsp_out_value,
   input  logic [COUNT_OUT_W-1:0] rsp_entry_count,
   output int                     fail_count,
   output int                     pending_count,
   output int                     checked_count,
   output int                     error_count,
   output int                     full_reject_count,
   output int                     delete_hit_count,
   output int                     peak_count
);

   typedef struct packed {
      logic                   status;
      logic [OUT_VALUE_W-1:0] out_value;
      logic [COUNT_OUT_W-1:0] entry_count;
   } tag_result_type;

   value_type      held_tags[$];      // slot 0 is the oldest entry
   tag_result_type expected_rsps[$];
   int             mismatches = 0;
   int             pending    = 0;
   int             checked    = 0;
   int             errors     = 0;
   int             full_rejects = 0;
   int             delete_hits  = 0;
   int             peak         = 0;

   assign fail_count        = mismatches;
   assign pending_count     = pending;
   assign checked_count     = checked;
   assign error_count       = errors;
   assign full_reject_count = full_rejects;
   assign delete_hit_count  = delete_hits;
   assign peak_count        = peak;

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("checker: %s mismatch, expected %0h got %0h at %0t", what, want, got,
               $realtime);
      mismatches++;
   endtask

   // Applies one command to the tracked queue and returns its result.
   function automatic tag_result_type apply_tag_command(input logic [ACTION_W-1:0] act,
                                                        input logic [ITEM_W-1:0] item);
      value_type      val;
      tag_result_type res;
      int             hit;
      val           = value_type'(item);
      res.status    = 1'b1;
      res.out_value = '0;
      hit           = -1;
      case (act)
         ACT_ENQ: begin
            if (val != '0 && held_tags.size() < DEPTH) begin
               held_tags.push_back(val);
               res.status = 1'b0;
            end
         end
         ACT_DEQ: begin
            if (held_tags.size() != 0) begin
               res.out_value = OUT_VALUE_W'(held_tags.pop_front());
               res.status    = 1'b0;
            end
         end
         ACT_DEL: begin
            if (val != '0) begin
               for (int i = 0; i < held_tags.size() && hit < 0; i++)
                  if (held_tags[i] == val) hit = i;
               if (hit >= 0) begin
                  held_tags.delete(hit);
                  res.status = 1'b0;
               end
            end
         end
         default: ;
      endcase
      res.entry_count = COUNT_OUT_W'(held_tags.size());
      return res;
   endfunction

   always @(posedge clock) begin : watch
      tag_result_type want;
      tag_result_type got;
      if (reset) begin
         held_tags.delete();
         expected_rsps.delete();
         pending = 0;
      end else begin
         // result of an earlier command; check before adding this edge's command
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_out_value);
            end else begin
               want = expected_rsps.pop_front();
               checked++;
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(rsp_status));
               if (rsp_out_value !== want.out_value)
                  report_mismatch("out_value", want.out_value, rsp_out_value);
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch("entry_count", 32'(want.entry_count),
                                  32'(rsp_entry_count));
            end
         end
         if (start && !busy) begin
            if (req_action == ACT_ENQ && held_tags.size() == DEPTH && req_item_value != '0)
               full_rejects++;
            got = apply_tag_command(req_action, req_item_value);
            if (got.status) errors++;
            if (req_action == ACT_DEL && !got.status) delete_hits++;
            if (held_tags.size() > peak) peak = held_tags.size();
            expected_rsps.push_back(got);
         end
         pending = expected_rsps.size();
      end
   end

endmodule

// ===== sim/fifo_queue_with_remove_by_value_unit_tb.sv =====
// Testbench top: drives tag queue commands, runs the checker and reports the verdict.
`timescale 1ns / 1ps

module fifo_queue_with_remove_by_value_unit_tb;
   import fqr_pkg::*;

   // action code the block must reject
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   // keep a wide margin over the slowest correct run
   localparam int CYCLE_LIMIT     = 200000;
   localparam int ITEMS_PER_PHASE = 350;
   localparam int BIAS_BLOCK      = 35;
   localparam int TAG_POOL        = 12;   // small tags repeat so deletes find matches

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [ACTION_W-1:0]    req_action;
   logic [ITEM_W-1:0]      req_item_value;
   logic                   rsp_valid;
   logic                   rsp_status;
   logic [OUT_VALUE_W-1:0] rsp_out_value;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;

   int fail_count;
   int pending_count;
   int checked_count;
   int error_count;
   int full_reject_count;
   int delete_hit_count;
   int peak_count;

   int cycle_count = 0;
   int sent_count  = 0;
   int idle_pct    = 0;   // chance, per cycle, that the sender holds start low

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fifo_queue_with_remove_by_value_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_out_value  (rsp_out_value),
      .rsp_entry_count(rsp_entry_count)
   );

   tag_queue_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_item_value   (req_item_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_value    (rsp_out_value),
      .rsp_entry_count  (rsp_entry_count),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count),
      .error_count      (error_count),
      .full_reject_count(full_reject_count),
      .delete_hit_count (delete_hit_count),
      .peak_count       (peak_count)
   );

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // One command transfer. Inputs move on the falling edge; the transfer
   // happens at the first rising edge with start high and busy low.
   // start stays high on return so back-to-back commands need no gap.
   task automatic send_cmd(input logic [ACTION_W-1:0] act, input logic [ITEM_W-1:0] val);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         // idle cycle with junk on the fields
         start          = 1'b0;
         req_action     = ACTION_W'($urandom());
         req_item_value = $urandom();
         @(negedge clock);
      end
      start          = 1'b1;
      req_action     = act;
      req_item_value = val;
      do @(posedge clock); while (busy);
      sent_count++;
   endtask

   // Tag for an enqueue or delete: mostly small repeating tags, some full-width
   // random ones (every bit toggles), a few zeros.
   function automatic logic [ITEM_W-1:0] pick_tag(input int wide_pct);
      int r;
      r = $urandom_range(99);
      if (r < 5) return '0;
      if (r < 5 + wide_pct) return $urandom();
      return ITEM_W'($urandom_range(TAG_POOL, 1));
   endfunction

   task automatic send_random_cmd(input int enq_pct);
      if ($urandom_range(99) < 3)
         send_cmd(ACT_UNUSED, pick_tag(30));
      else if ($urandom_range(99) < enq_pct)
         send_cmd(ACT_ENQ, pick_tag(25));
      else if ($urandom_range(1) == 0)
         send_cmd(ACT_DEQ, $urandom());
      else
         send_cmd(ACT_DEL, pick_tag(20));
   endtask

   initial begin
      int phase_idle[3];
      reset          = 1'b1;
      start          = 1'b0;
      req_action     = ACT_ENQ;
      req_item_value = '0;
      phase_idle     = '{0, 68, 28};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: errors on an empty queue, zero tag, unused action code
      send_cmd(ACT_DEQ, 32'h0);
      send_cmd(ACT_DEL, 32'h1);
      send_cmd(ACT_ENQ, 32'h0);
      send_cmd(ACT_UNUSED, 32'hFFFF_FFFF);
      // field extremes and a duplicate tag
      send_cmd(ACT_ENQ, 32'hFFFF_FFFF);
      send_cmd(ACT_ENQ, 32'h1);
      send_cmd(ACT_ENQ, 32'h8000_0000);
      send_cmd(ACT_ENQ, 32'h1);
      // delete takes the oldest of the duplicates, then the tail entry twice
      send_cmd(ACT_DEL, 32'h1);
      send_cmd(ACT_DEL, 32'h1);
      send_cmd(ACT_DEL, 32'h8000_0000);
      // no match, zero tag on a non-empty queue, then drain
      send_cmd(ACT_DEL, 32'h7);
      send_cmd(ACT_DEL, 32'h0);
      send_cmd(ACT_DEQ, 32'h0);
      // fill past full, then drop a middle entry
      for (int i = 0; i <= DEPTH; i++) send_cmd(ACT_ENQ, ITEM_W'(i % 5 + 2));
      send_cmd(ACT_DEL, 32'h4);

      // Random: per phase a different sender idle rate; inside a phase the
      // mix swings between filling and draining so full and empty both recur.
      for (int p = 0; p < 3; p++) begin
         idle_pct = phase_idle[p];
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_random_cmd(((n / BIAS_BLOCK) % 2 == 0) ? 80 : 25);
      end

      @(negedge clock);
      start = 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("tb: %0d commands sent, %0d results checked, %0d error results",
               sent_count, checked_count, error_count);
      $display("tb: %0d full rejects, %0d matched deletes, peak depth %0d",
               full_reject_count, delete_hit_count, peak_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
